[rtl/core/spq_pkg.sv]
// Shared types and constants of the sorted priority queue.
// Used by the controller, the datapath, the top level and the checker.
package spq_pkg;

	localparam int CAPACITY      = 16;
	localparam int KEY_BITS      = 16;
	localparam int PAYLOAD_BITS  = 32;
	localparam int CNT_BITS      = $clog2(CAPACITY + 1);
	localparam int CFG_ADDR_BITS = 3;

	localparam logic [1:0] KIND_ENQ  = 2'd0;
	localparam logic [1:0] KIND_DEQ  = 2'd1;
	localparam logic [1:0] KIND_PEEK = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam logic REG_ORDERED_MODE = 1'b0;

	typedef struct packed {
		logic load_in;
		logic exec;
	} spq_cmd_t;

endpackage

[rtl/core/spq_ctrl.sv]
// Controller of the sorted priority queue: sequences capture and execution.
// Depends on spq_pkg.
module spq_ctrl
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output spq_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd.load_in = (state_q == ST_IDLE) && in_valid;
		cmd.exec    = (state_q == ST_EXEC) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/spq_dp.sv]
// Datapath of the sorted priority queue: entry cells, count and result register.
// Depends on spq_pkg.
module spq_dp
	import spq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  spq_cmd_t                cmd,
	input  logic                    ordered_mode,
	input  logic [1:0]              kind,
	input  logic [KEY_BITS-1:0]     key,
	input  logic [PAYLOAD_BITS-1:0] payload,
	output logic [1:0]              status,
	output logic [PAYLOAD_BITS-1:0] out_payload,
	output logic [KEY_BITS-1:0]     out_key,
	output logic [CNT_BITS-1:0]     occupancy
);

	logic [1:0]              kind_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] payload_q;

	logic [KEY_BITS-1:0]     keys_q [CAPACITY];
	logic [PAYLOAD_BITS-1:0] pays_q [CAPACITY];
	logic [CNT_BITS-1:0]     count_q;

	logic [1:0]              status_q;
	logic [PAYLOAD_BITS-1:0] out_payload_q;
	logic [KEY_BITS-1:0]     out_key_q;
	logic [CNT_BITS-1:0]     occupancy_q;

	logic [CAPACITY-1:0] le_vec;
	logic [CAPACITY-1:0] above;
	logic                is_full;
	logic                is_empty;
	logic                do_enq;
	logic                do_deq;

	assign is_full  = (count_q == CNT_BITS'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign do_enq   = cmd.exec && (kind_q == KIND_ENQ) && !is_full;
	assign do_deq   = cmd.exec && (kind_q == KIND_DEQ) && !is_empty;

	// A cell is a landing bound when it is occupied and its key is not larger
	// than the new key; in FIFO mode every occupied cell is one.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			le_vec[i] = (CNT_BITS'(i) < count_q) &&
				(!ordered_mode || (keys_q[i] <= key_q));
		end
		for (int i = 0; i < CAPACITY; i++) begin
			above[i] = ((le_vec >> i) != '0);
		end
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic                    take_new;
			logic                    take_low;
			logic [KEY_BITS-1:0]     low_key;
			logic [PAYLOAD_BITS-1:0] low_pay;
			logic [KEY_BITS-1:0]     high_key;
			logic [PAYLOAD_BITS-1:0] high_pay;

			if (g == 0) begin : g_first
				assign take_new = !above[g];
				assign take_low = 1'b0;
				assign low_key  = key_q;
				assign low_pay  = payload_q;
			end else begin : g_rest
				assign take_new = !above[g] && above[g-1];
				assign take_low = !above[g-1];
				assign low_key  = keys_q[g-1];
				assign low_pay  = pays_q[g-1];
			end

			if (g == CAPACITY - 1) begin : g_last
				assign high_key = keys_q[g];
				assign high_pay = pays_q[g];
			end else begin : g_mid
				assign high_key = keys_q[g+1];
				assign high_pay = pays_q[g+1];
			end

			always_ff @(posedge clk) begin
				if (do_enq) begin
					if (take_new) begin
						keys_q[g] <= key_q;
						pays_q[g] <= payload_q;
					end else if (take_low) begin
						keys_q[g] <= low_key;
						pays_q[g] <= low_pay;
					end
				end else if (do_deq) begin
					keys_q[g] <= high_key;
					pays_q[g] <= high_pay;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_enq) begin
			count_q <= count_q + 1'b1;
		end else if (do_deq) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q    <= kind;
			key_q     <= key;
			payload_q <= payload;
		end
		if (cmd.exec) begin
			status_q      <= STAT_OK;
			out_payload_q <= '0;
			out_key_q     <= '0;
			occupancy_q   <= count_q;
			case (kind_q)
				KIND_ENQ: begin
					if (is_full) begin
						status_q <= STAT_FULL;
					end else begin
						occupancy_q <= count_q + 1'b1;
					end
				end
				KIND_DEQ, KIND_PEEK: begin
					if (is_empty) begin
						status_q <= STAT_EMPTY;
					end else begin
						out_payload_q <= pays_q[0];
						out_key_q     <= keys_q[0];
						if (kind_q == KIND_DEQ) begin
							occupancy_q <= count_q - 1'b1;
						end
					end
				end
				default: begin
					status_q <= STAT_OK;
				end
			endcase
		end
	end

	assign status      = status_q;
	assign out_payload = out_payload_q;
	assign out_key     = out_key_q;
	assign occupancy   = occupancy_q;

endmodule

[rtl/core/sorted_priority_queue.sv]
// Sorted priority queue: one operation per transfer; one item is in work at a time.
// The controller captures each input transfer and then executes it; a stalled
// result holds the next item in execute, as execution waits for a free result slot.
// Reset clears the entry count, the handshake state and selects ordered mode;
// entry contents are left as they are and are never read before being written.
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// Input channel.
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               kind,
	input  logic [KEY_BITS-1:0]      key,
	input  logic [PAYLOAD_BITS-1:0]  payload,
	// Result channel.
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [PAYLOAD_BITS-1:0]  out_payload,
	output logic [KEY_BITS-1:0]      out_key,
	output logic [CNT_BITS-1:0]      occupancy,
	// Configuration port.
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	spq_cmd_t cmd;
	logic     ordered_mode_q;
	logic     reg_sel;

	// The single register sits at byte address zero; bit 2 of the address
	// is the register index, so any other word is outside the register list.
	assign reg_sel = (paddr[2] == REG_ORDERED_MODE);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ordered_mode_q <= 1'b1;
		end else if (psel && penable && pwrite && reg_sel) begin
			ordered_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[0] = ordered_mode_q;
		end
	end

	// The controller decides when an item is captured and when it is executed;
	// execution waits until the result register is empty or being drained.
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// The datapath holds the entries as a row of cells whose affected cells shift at once,
	// so an insert or a removal completes in the execute cycle.
	spq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.ordered_mode (ordered_mode_q),
		.kind         (kind),
		.key          (key),
		.payload      (payload),
		.status       (status),
		.out_payload  (out_payload),
		.out_key      (out_key),
		.occupancy    (occupancy)
	);

endmodule

[rtl/core/spq_checker.sv]
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg.
module spq_checker
	import spq_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [1:0]              status,
	input logic [PAYLOAD_BITS-1:0] out_payload,
	input logic [KEY_BITS-1:0]     out_key,
	input logic [CNT_BITS-1:0]     occupancy
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again in the cycle after a transfer");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= CNT_BITS'(CAPACITY))
		else $error("occupancy beyond capacity");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> occupancy == CNT_BITS'(CAPACITY))
		else $error("full status with free space");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |->
			occupancy == '0 && out_key == '0 && out_payload == '0)
		else $error("empty status with stored entries or data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.out_payload (out_payload),
	.out_key     (out_key),
	.occupancy   (occupancy)
);
